>>> rtl/ray_sphere_intersect_assert.svh
// assertion macros for the ray-sphere block
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RSI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsi check failed");
`define RSI_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rsi check failed");
`else
`define RSI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RSI_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

>>> rtl/rsi_pkg.sv
package rsi_pkg;

    localparam int COORD_W     = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        REG_CENTER_X      = 2'd0,
        REG_CENTER_Y      = 2'd1,
        REG_CENTER_Z      = 2'd2,
        REG_RADIUS_SQUARED = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] min_time;
        logic signed [COORD_W-1:0] max_time;
    } t_req;

    typedef struct packed {
        logic                      hit;
        logic                      far_root;
        logic signed [COORD_W-1:0] hit_time;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
        logic                      degenerate;
    } t_res;

    typedef struct packed {
        t_req req;
        logic deg;
    } t_item;

    function automatic logic signed [63:0] s64(input logic signed [COORD_W-1:0] v);
        return {{(64-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sneg(input logic signed [63:0] x);
        return (x == S64_MIN) ? S64_MAX : -x;
    endfunction

    function automatic logic signed [COORD_W-1:0] outw(input logic signed [63:0] v);
        if (&v[63:COORD_W-1] || ~|v[63:COORD_W-1]) begin
            return v[COORD_W-1:0];
        end
        return v[63] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

>>> rtl/rsi_mul.sv
module rsi_mul #(
    parameter int LANES     = 1,
    parameter int SIDE_W    = 1,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [LANES-1:0][63:0] i_a,
    input  logic [LANES-1:0][63:0] i_b,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [LANES-1:0][63:0] o_p,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] r_v;
    logic [SIDE_W-1:0] r_side [STAGES];

    logic [63:0]  n_ma [LANES], n_mb [LANES];
    logic [64:0]  n_mid [LANES];
    logic [127:0] n_prod [LANES], n_sv [LANES];
    logic [63:0]  n_out [LANES];

    logic         r_neg1 [LANES], r_neg2 [LANES], r_neg3 [LANES], r_neg4 [LANES];
    logic [63:0]  r_ma [LANES], r_mb [LANES];
    logic [63:0]  r_p00 [LANES], r_p01 [LANES], r_p10 [LANES], r_p11 [LANES];
    logic [63:0]  r_lo [LANES], r_hi [LANES];
    logic [64:0]  r_mid [LANES];
    logic [127:0] r_prod [LANES], r_sv [LANES];
    logic [63:0]  r_out [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_ma[l]   = i_a[l][63] ? -i_a[l] : i_a[l];
            n_mb[l]   = i_b[l][63] ? -i_b[l] : i_b[l];
            n_mid[l]  = {1'b0, r_p01[l]} + {1'b0, r_p10[l]};
            n_prod[l] = {r_hi[l], r_lo[l]} + (128'(r_mid[l]) << 32);
            n_sv[l]   = r_neg4[l] ? -r_prod[l] : r_prod[l];
        end
    end

    always_comb begin
        logic [127:0] sh;
        for (int l = 0; l < LANES; l++) begin
            sh = 128'($signed(r_sv[l]) >>> FRAC_BITS);
            if (&sh[127:63] || ~|sh[127:63]) begin
                n_out[l] = sh[63:0];
            end else begin
                n_out[l] = sh[127] ? rsi_pkg::S64_MIN : rsi_pkg::S64_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int l = 0; l < LANES; l++) begin
                r_neg1[l] <= i_a[l][63] ^ i_b[l][63];
                r_ma[l]   <= n_ma[l];
                r_mb[l]   <= n_mb[l];
                r_neg2[l] <= r_neg1[l];
                r_p00[l]  <= 64'(r_ma[l][31:0])  * 64'(r_mb[l][31:0]);
                r_p01[l]  <= 64'(r_ma[l][31:0])  * 64'(r_mb[l][63:32]);
                r_p10[l]  <= 64'(r_ma[l][63:32]) * 64'(r_mb[l][31:0]);
                r_p11[l]  <= 64'(r_ma[l][63:32]) * 64'(r_mb[l][63:32]);
                r_neg3[l] <= r_neg2[l];
                r_lo[l]   <= r_p00[l];
                r_hi[l]   <= r_p11[l];
                r_mid[l]  <= n_mid[l];
                r_neg4[l] <= r_neg3[l];
                r_prod[l] <= n_prod[l];
                r_sv[l]   <= n_sv[l];
                r_out[l]  <= n_out[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_p[l] = r_out[l];
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

>>> rtl/rsi_sqrt.sv
module rsi_sqrt #(
    parameter int SIDE_W    = 1,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_d,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [63:0]       o_s,
    output logic [SIDE_W-1:0] o_side
);

    localparam int RB = (64 + FRAC_BITS + 1) / 2;
    localparam int NB = 2 * RB;

    logic [RB:0]       r_v;
    logic [SIDE_W-1:0] r_side [RB+1];
    logic [NB-1:0]     r_rad  [RB];
    logic [RB+1:0]     r_rem  [RB];
    logic [RB-1:0]     r_root [RB+1];

    logic [RB+1:0] n_rem  [RB];
    logic [RB-1:0] n_root [RB];

    always_comb begin
        logic [RB+1:0] rem2, trial;
        logic          ge;
        for (int s = 0; s < RB; s++) begin
            rem2 = {r_rem[s][RB-1:0], r_rad[s][NB-1 -: 2]};
            trial = {r_root[s], 2'b01};
            ge = rem2 >= trial;
            n_rem[s]  = ge ? rem2 - trial : rem2;
            n_root[s] = {r_root[s][RB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_rad[0]  <= NB'({i_d, {FRAC_BITS{1'b0}}});
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int s = 1; s <= RB; s++) begin
                r_side[s] <= r_side[s-1];
                r_root[s] <= n_root[s-1];
                if (s < RB) begin
                    r_rem[s] <= n_rem[s-1];
                    r_rad[s] <= r_rad[s-1] << 2;
                end
            end
        end
    end

    assign o_valid = r_v[RB];
    assign o_s     = 64'(r_root[RB]);
    assign o_side  = r_side[RB];

endmodule

>>> rtl/rsi_div.sv
module rsi_div #(
    parameter int LANES     = 1,
    parameter int SIDE_W    = 1,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [LANES-1:0][63:0] i_n,
    input  logic [63:0]            i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [LANES-1:0][63:0] o_q,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int QB = 64 + FRAC_BITS;

    logic [QB+1:0]     r_v;
    logic [SIDE_W-1:0] r_side [QB+2];
    logic [63:0]       r_den  [QB];
    logic [QB-1:0]     r_dvd  [QB][LANES];
    logic [63:0]       r_rem  [QB][LANES];
    logic [QB-1:0]     r_q    [QB+1][LANES];
    logic              r_neg  [QB+1][LANES];
    logic [63:0]       r_out  [LANES];

    logic [63:0]   n_rem [QB][LANES];
    logic [QB-1:0] n_q   [QB][LANES];
    logic [63:0]   n_mag [LANES];
    logic [63:0]   n_out [LANES];

    always_comb begin
        logic [64:0] rem2;
        logic        ge;
        for (int s = 0; s < QB; s++) begin
            for (int l = 0; l < LANES; l++) begin
                rem2 = {r_rem[s][l], r_dvd[s][l][QB-1]};
                ge = rem2 >= {1'b0, r_den[s]};
                n_rem[s][l] = ge ? 64'(rem2 - {1'b0, r_den[s]}) : rem2[63:0];
                n_q[s][l]   = {r_q[s][l][QB-2:0], ge};
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_mag[l] = i_n[l][63] ? -i_n[l] : i_n[l];
            if (|r_q[QB][l][QB-1:63]) begin
                n_out[l] = r_neg[QB][l] ? rsi_pkg::S64_MIN : rsi_pkg::S64_MAX;
            end else begin
                n_out[l] = r_neg[QB][l] ? -r_q[QB][l][63:0] : r_q[QB][l][63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            for (int s = 1; s < QB + 2; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int s = 1; s < QB; s++) begin
                r_den[s] <= r_den[s-1];
            end
            for (int l = 0; l < LANES; l++) begin
                r_dvd[0][l] <= {n_mag[l], {FRAC_BITS{1'b0}}};
                r_rem[0][l] <= '0;
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_n[l][63];
                for (int s = 1; s <= QB; s++) begin
                    r_q[s][l]   <= n_q[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                    if (s < QB) begin
                        r_rem[s][l] <= n_rem[s-1][l];
                        r_dvd[s][l] <= r_dvd[s-1][l] << 1;
                    end
                end
                r_out[l] <= n_out[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_q[l] = r_out[l];
        end
    end

    assign o_valid = r_v[QB+1];
    assign o_side  = r_side[QB+1];

endmodule

>>> rtl/rsi_queue.sv
module rsi_queue #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = rsi_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

>>> rtl/rsi_front.sv
module rsi_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  rsi_pkg::t_req  i_req,
    output logic           o_req_stall,
    input  logic           i_q_full,
    output logic           o_push,
    output rsi_pkg::t_item o_item
);

    logic           r_f_valid, n_f_valid;
    rsi_pkg::t_item r_f_item;
    logic           load;

    assign o_req_stall = r_f_valid && i_q_full;
    assign load        = i_req_valid && !o_req_stall;
    assign o_push      = r_f_valid && !i_q_full;
    assign n_f_valid   = load || (r_f_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= n_f_valid;
        end
    end

    // zero direction is flagged here and carried as a miss
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_f_item.req <= i_req;
            r_f_item.deg <= (i_req.dir_x == '0) && (i_req.dir_y == '0)
                            && (i_req.dir_z == '0);
        end
    end

    assign o_item = r_f_item;

endmodule

>>> rtl/rsi_back.sv
module rsi_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  rsi_pkg::t_item                     i_item,
    input  logic signed [rsi_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [rsi_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [rsi_pkg::COORD_W-1:0] i_center_z,
    input  logic [rsi_pkg::COORD_W-1:0]        i_radius_sq,
    output logic                               o_valid,
    output rsi_pkg::t_res                      o_res
);

    typedef struct packed {
        rsi_pkg::t_item    it;
        logic              miss;
        logic signed [63:0] a;
        logic signed [63:0] h;
    } t_s2;

    typedef struct packed {
        rsi_pkg::t_item it;
        logic           miss;
    } t_s4;

    typedef struct packed {
        rsi_pkg::t_item    it;
        logic              hit;
        logic              far;
        logic signed [63:0] t;
    } t_s5;

    localparam int IT_W = $bits(rsi_pkg::t_item);
    localparam int S2_W = $bits(t_s2);
    localparam int S4_W = $bits(t_s4);
    localparam int S5_W = $bits(t_s5);

    // stage a: offsets from the center
    logic               r_a_v;
    rsi_pkg::t_item     r_a_it;
    logic signed [63:0] r_cx, r_cy, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_it <= i_item;
            r_cx   <= rsi_pkg::s64(i_item.req.origin_x) - rsi_pkg::s64(i_center_x);
            r_cy   <= rsi_pkg::s64(i_item.req.origin_y) - rsi_pkg::s64(i_center_y);
            r_cz   <= rsi_pkg::s64(i_item.req.origin_z) - rsi_pkg::s64(i_center_z);
        end
    end

    // dot products
    logic [8:0][63:0] m1_a, m1_b, m1_p;
    logic             m1_v;
    logic [IT_W-1:0]  m1_side;
    rsi_pkg::t_item   m1_it;
    logic signed [63:0] dx, dy, dz;

    assign dx = rsi_pkg::s64(r_a_it.req.dir_x);
    assign dy = rsi_pkg::s64(r_a_it.req.dir_y);
    assign dz = rsi_pkg::s64(r_a_it.req.dir_z);

    always_comb begin
        m1_a[0] = dx;   m1_b[0] = dx;
        m1_a[1] = dy;   m1_b[1] = dy;
        m1_a[2] = dz;   m1_b[2] = dz;
        m1_a[3] = r_cx; m1_b[3] = dx;
        m1_a[4] = r_cy; m1_b[4] = dy;
        m1_a[5] = r_cz; m1_b[5] = dz;
        m1_a[6] = r_cx; m1_b[6] = r_cx;
        m1_a[7] = r_cy; m1_b[7] = r_cy;
        m1_a[8] = r_cz; m1_b[8] = r_cz;
    end

    rsi_mul #(.LANES(9), .SIDE_W(IT_W), .FRAC_BITS(FRAC_BITS)) u_mul_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_a_v),
        .i_a     (m1_a),
        .i_b     (m1_b),
        .i_side  (r_a_it),
        .o_valid (m1_v),
        .o_p     (m1_p),
        .o_side  (m1_side)
    );

    assign m1_it = m1_side;

    // sums, one saturating add per stage
    logic               r_b1_v, r_b2_v, r_b3_v;
    rsi_pkg::t_item     r_b1_it, r_b2_it;
    logic signed [63:0] r_a1, r_h1, r_k1, r_zz, r_cdz, r_czz;
    logic signed [63:0] r_a2, r_h2, r_k2;
    t_s2                r_b3;
    logic signed [63:0] r_k3;
    logic signed [63:0] neg_r2;

    assign neg_r2 = -{{(64-rsi_pkg::COORD_W){1'b0}}, i_radius_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
        end else if (i_en) begin
            r_b1_v <= m1_v;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_it   <= m1_it;
            r_a1      <= rsi_pkg::sadd(m1_p[0], m1_p[1]);
            r_h1      <= rsi_pkg::sadd(m1_p[3], m1_p[4]);
            r_k1      <= rsi_pkg::sadd(m1_p[6], m1_p[7]);
            r_zz      <= m1_p[2];
            r_cdz     <= m1_p[5];
            r_czz     <= m1_p[8];
            r_b2_it   <= r_b1_it;
            r_a2      <= rsi_pkg::sadd(r_a1, r_zz);
            r_h2      <= rsi_pkg::sadd(r_h1, r_cdz);
            r_k2      <= rsi_pkg::sadd(r_k1, r_czz);
            r_b3.it   <= r_b2_it;
            r_b3.miss <= r_b2_it.deg || (r_a2 <= 0);
            r_b3.a    <= r_a2;
            r_b3.h    <= r_h2;
            r_k3      <= rsi_pkg::sadd(r_k2, neg_r2);
        end
    end

    // h*h and a*k
    logic [1:0][63:0] m2_a, m2_b, m2_p;
    logic             m2_v;
    logic [S2_W-1:0]  m2_side;
    t_s2              m2_s;

    always_comb begin
        m2_a[0] = r_b3.h; m2_b[0] = r_b3.h;
        m2_a[1] = r_b3.a; m2_b[1] = r_k3;
    end

    rsi_mul #(.LANES(2), .SIDE_W(S2_W), .FRAC_BITS(FRAC_BITS)) u_mul_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_b3_v),
        .i_a     (m2_a),
        .i_b     (m2_b),
        .i_side  (r_b3),
        .o_valid (m2_v),
        .o_p     (m2_p),
        .o_side  (m2_side)
    );

    assign m2_s = m2_side;

    // discriminant
    logic               r_d1_v, r_d2_v;
    t_s2                r_d1, r_d2;
    logic signed [63:0] r_hh, r_nak, r_disc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
        end else if (i_en) begin
            r_d1_v <= m2_v;
            r_d2_v <= r_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] disc;
        if (i_en) begin
            disc      = rsi_pkg::sadd(r_hh, r_nak);
            r_d1      <= m2_s;
            r_hh      <= m2_p[0];
            r_nak     <= rsi_pkg::sneg(m2_p[1]);
            r_d2.it   <= r_d1.it;
            r_d2.a    <= r_d1.a;
            r_d2.h    <= r_d1.h;
            r_d2.miss <= r_d1.miss || disc[63];
            r_disc    <= disc[63] ? '0 : disc;
        end
    end

    // square root
    logic            sq_v;
    logic [63:0]     sq_s;
    logic [S2_W-1:0] sq_side;
    t_s2             sq_x;

    rsi_sqrt #(.SIDE_W(S2_W), .FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_d2_v),
        .i_d     (r_disc),
        .i_side  (r_d2),
        .o_valid (sq_v),
        .o_s     (sq_s),
        .o_side  (sq_side)
    );

    assign sq_x = sq_side;

    // root numerators
    logic               r_e1_v, r_e2_v;
    t_s4                r_e1, r_e2;
    logic signed [63:0] r_e1_a, r_e2_a, r_nh, r_s, r_n1, r_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
        end else if (i_en) begin
            r_e1_v <= sq_v;
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1.it   <= sq_x.it;
            r_e1.miss <= sq_x.miss;
            r_e1_a    <= sq_x.a;
            r_nh      <= rsi_pkg::sneg(sq_x.h);
            r_s       <= sq_s;
            r_e2      <= r_e1;
            r_e2_a    <= r_e1_a;
            r_n1      <= rsi_pkg::sadd(r_nh, -r_s);
            r_n2      <= rsi_pkg::sadd(r_nh, r_s);
        end
    end

    // both roots
    logic [1:0][63:0] dv_n, dv_q;
    logic             dv_v;
    logic [S4_W-1:0]  dv_side;
    t_s4              dv_x;

    assign dv_n[0] = r_n1;
    assign dv_n[1] = r_n2;

    rsi_div #(.LANES(2), .SIDE_W(S4_W), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_e2_v),
        .i_n     (dv_n),
        .i_den   (r_e2_a),
        .i_side  (r_e2),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    assign dv_x = dv_side;

    // root selection
    logic               r_g_v;
    t_s5                r_g;
    logic signed [63:0] t1, t2, tmin, tmax;
    logic               in1, in2;

    assign t1   = dv_q[0];
    assign t2   = dv_q[1];
    assign tmin = rsi_pkg::s64(dv_x.it.req.min_time);
    assign tmax = rsi_pkg::s64(dv_x.it.req.max_time);
    assign in1  = (t1 >= tmin) && (t1 <= tmax);
    assign in2  = (t2 >= tmin) && (t2 <= tmax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_g_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g.it  <= dv_x.it;
            r_g.hit <= !dv_x.miss && (in1 || in2);
            r_g.far <= !in1;
            r_g.t   <= in1 ? t1 : t2;
        end
    end

    // hit point
    logic [2:0][63:0] m3_a, m3_b, m3_p;
    logic             m3_v;
    logic [S5_W-1:0]  m3_side;
    t_s5              m3_x;

    always_comb begin
        m3_a[0] = r_g.t; m3_b[0] = rsi_pkg::s64(r_g.it.req.dir_x);
        m3_a[1] = r_g.t; m3_b[1] = rsi_pkg::s64(r_g.it.req.dir_y);
        m3_a[2] = r_g.t; m3_b[2] = rsi_pkg::s64(r_g.it.req.dir_z);
    end

    rsi_mul #(.LANES(3), .SIDE_W(S5_W), .FRAC_BITS(FRAC_BITS)) u_mul_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_g_v),
        .i_a     (m3_a),
        .i_b     (m3_b),
        .i_side  (r_g),
        .o_valid (m3_v),
        .o_p     (m3_p),
        .o_side  (m3_side)
    );

    assign m3_x = m3_side;

    // output register
    logic          r_out_v;
    rsi_pkg::t_res r_out, n_out;

    always_comb begin
        n_out            = '0;
        n_out.degenerate = m3_x.it.deg;
        if (m3_x.hit) begin
            n_out.hit      = 1'b1;
            n_out.far_root = m3_x.far;
            n_out.hit_time = rsi_pkg::outw(m3_x.t);
            n_out.hit_x    = rsi_pkg::outw(rsi_pkg::sadd(
                                 rsi_pkg::s64(m3_x.it.req.origin_x), m3_p[0]));
            n_out.hit_y    = rsi_pkg::outw(rsi_pkg::sadd(
                                 rsi_pkg::s64(m3_x.it.req.origin_y), m3_p[1]));
            n_out.hit_z    = rsi_pkg::outw(rsi_pkg::sadd(
                                 rsi_pkg::s64(m3_x.it.req.origin_z), m3_p[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= m3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

>>> rtl/ray_sphere_intersect.sv
// Ray against sphere test, signed fixed point with FRAC_BITS fraction bits.
// Sphere center and squared radius are written over the APB-style port at
// byte addresses 0, 4, 8 and 12; write them only while no ray is in flight.
// Request channel: i_req_valid with i_req (origin, direction, time range),
// taken at an edge where i_req_valid is high and o_req_stall is low.
// Result channel: o_res_valid with o_res (hit, far_root, hit_time,
// hit_x/y/z, degenerate), taken when o_res_valid is high and i_res_stall low.
// Without stalls one request is accepted and one result delivered per cycle.
// The pipeline depth is set mostly by the bit-per-stage square root and the
// bit-per-stage divider for the two roots, and each pass through the
// pipelined 64-bit multipliers adds to it.
// A front register and a four-entry queue hold requests while the back
// pipeline is held; i_res_stall with o_res_valid high freezes the whole
// back pipeline with the result kept in the output register, and
// o_req_stall rises once the queue is full and the front register holds a
// request. Reset empties the pipeline and queue, sets the center to zero and
// the squared radius to 1.0.
module ray_sphere_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  rsi_pkg::t_req i_req,
    output logic          o_req_stall,
    output logic          o_res_valid,
    output rsi_pkg::t_res o_res,
    input  logic          i_res_stall,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    `include "ray_sphere_intersect_assert.svh"

    localparam int IT_W = $bits(rsi_pkg::t_item);

    logic signed [rsi_pkg::COORD_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [rsi_pkg::COORD_W-1:0]        r_radius_sq;
    rsi_pkg::t_reg_idx                  reg_idx;
    logic                               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = rsi_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_center_z  <= '0;
            r_radius_sq <= rsi_pkg::COORD_W'(1) << FRAC_BITS;
        end else if (cfg_wr) begin
            case (reg_idx)
                rsi_pkg::REG_CENTER_X:       r_center_x  <= pwdata;
                rsi_pkg::REG_CENTER_Y:       r_center_y  <= pwdata;
                rsi_pkg::REG_CENTER_Z:       r_center_z  <= pwdata;
                rsi_pkg::REG_RADIUS_SQUARED: r_radius_sq <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rsi_pkg::REG_CENTER_X:       prdata = r_center_x;
            rsi_pkg::REG_CENTER_Y:       prdata = r_center_y;
            rsi_pkg::REG_CENTER_Z:       prdata = r_center_z;
            rsi_pkg::REG_RADIUS_SQUARED: prdata = r_radius_sq;
            default:                     prdata = '0;
        endcase
    end

    logic           q_full, q_empty, q_push, q_pop, en;
    rsi_pkg::t_item f_item;
    logic [IT_W-1:0] q_data;

    rsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_item      (f_item)
    );

    assign en    = !(o_res_valid && i_res_stall);
    assign q_pop = en && !q_empty;

    rsi_queue #(.WIDTH(IT_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_item),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (q_pop),
        .i_item      (q_data),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .i_center_z  (r_center_z),
        .i_radius_sq (r_radius_sq),
        .o_valid     (o_res_valid),
        .o_res       (o_res)
    );

    `RSI_ASSERT_IMPLIES(a_deg_miss, i_clk, i_rst_n, o_res_valid && o_res.degenerate, !o_res.hit)
    `RSI_ASSERT_IMPLIES(a_far_hit, i_clk, i_rst_n, o_res_valid && o_res.far_root, o_res.hit)
    `RSI_ASSERT_IMPLIES(a_miss_zero, i_clk, i_rst_n, o_res_valid && !o_res.hit, o_res.hit_time == '0 && o_res.hit_x == '0)
    `RSI_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, q_push && q_full)

endmodule

>>> tb/ray_sphere_intersect_tb.sv
module ray_sphere_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam logic signed [63:0] Q_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] C_MAX = 32'h7fff_ffff;
    localparam int DRAIN_CYCLES = 250;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_req_valid;
    rsi_pkg::t_req i_req;
    logic          o_req_stall;
    logic          o_res_valid;
    rsi_pkg::t_res o_res;
    logic          i_res_stall = 1'b0;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    logic signed [31:0] sph_cx, sph_cy, sph_cz;
    logic [31:0]        sph_r2;

    rsi_pkg::t_res pending_results[$];
    int            errors;
    int            req_idle_pct;
    int            res_idle_pct;

    ray_sphere_intersect dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .i_req      (i_req),
        .o_req_stall(o_req_stall),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_res_stall(i_res_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // fixed point helpers, all in 64-bit Q47.16 with saturation
    function automatic logic signed [63:0] add_sat(logic signed [63:0] x,
                                                   logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] neg_sat(logic signed [63:0] x);
        return (x == Q_MIN) ? Q_MAX : -x;
    endfunction

    function automatic logic signed [63:0] mul_fx(logic signed [63:0] x,
                                                  logic signed [63:0] y);
        logic signed [127:0] xe, ye, p;
        xe = x;
        ye = y;
        p = (xe * ye) >>> FRAC;
        if (&p[127:63] || ~|p[127:63]) return p[63:0];
        return p[127] ? Q_MIN : Q_MAX;
    endfunction

    function automatic logic signed [63:0] div_fx(logic signed [63:0] n,
                                                  logic signed [63:0] a);
        logic signed [127:0] ne;
        logic [127:0] m, q;
        ne = n;
        m = (n < 0) ? -ne : ne;
        q = (m << FRAC) / {64'd0, a};
        if (q >= (128'd1 << 63)) return (n < 0) ? Q_MIN : Q_MAX;
        return (n < 0) ? -q[63:0] : q[63:0];
    endfunction

    function automatic logic signed [63:0] sqrt_fx(logic signed [63:0] d);
        logic [127:0] nn, r, c;
        nn = {64'd0, d} << FRAC;
        r = '0;
        for (int b = 47; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= nn) r = c;
        end
        return r[63:0];
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [63:0] v);
        if (v > 64'sh7fff_ffff) return C_MAX;
        if (v < -64'sh8000_0000) return C_MIN;
        return v[31:0];
    endfunction

    function automatic rsi_pkg::t_res trace_ray(rsi_pkg::t_req r);
        rsi_pkg::t_res res;
        logic signed [63:0] ox, oy, oz, dx, dy, dz, tmin, tmax;
        logic signed [63:0] cx, cy, cz, a, h, k, disc, s, nh, t1, t2, t;
        ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
        dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
        tmin = r.min_time; tmax = r.max_time;
        res = '0;
        if (dx == 0 && dy == 0 && dz == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        cx = ox - 64'(sph_cx);
        cy = oy - 64'(sph_cy);
        cz = oz - 64'(sph_cz);
        a = add_sat(add_sat(mul_fx(dx, dx), mul_fx(dy, dy)), mul_fx(dz, dz));
        if (a <= 0) return res;
        h = add_sat(add_sat(mul_fx(cx, dx), mul_fx(cy, dy)), mul_fx(cz, dz));
        k = add_sat(add_sat(add_sat(mul_fx(cx, cx), mul_fx(cy, cy)), mul_fx(cz, cz)),
                    -$signed({32'd0, sph_r2}));
        disc = add_sat(mul_fx(h, h), neg_sat(mul_fx(a, k)));
        if (disc < 0) return res;
        s = sqrt_fx(disc);
        nh = neg_sat(h);
        t1 = div_fx(add_sat(nh, -s), a);
        t2 = div_fx(add_sat(nh, s), a);
        if (t1 >= tmin && t1 <= tmax) begin
            t = t1;
        end else if (t2 >= tmin && t2 <= tmax) begin
            t = t2;
            res.far_root = 1'b1;
        end else begin
            return res;
        end
        res.hit = 1'b1;
        res.hit_time = clip32(t);
        res.hit_x = clip32(add_sat(ox, mul_fx(t, dx)));
        res.hit_y = clip32(add_sat(oy, mul_fx(t, dy)));
        res.hit_z = clip32(add_sat(oz, mul_fx(t, dz)));
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // result checker and result-side stall
    always @(posedge i_clk) begin
        rsi_pkg::t_res want;
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_res.hit_time), 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_res.hit !== want.hit)
                        report_mismatch("hit", 64'(o_res.hit), 64'(want.hit));
                    if (o_res.far_root !== want.far_root)
                        report_mismatch("far_root", 64'(o_res.far_root),
                                        64'(want.far_root));
                    if (o_res.hit_time !== want.hit_time)
                        report_mismatch("hit_time", 64'(o_res.hit_time),
                                        64'(want.hit_time));
                    if (o_res.hit_x !== want.hit_x)
                        report_mismatch("hit_x", 64'(o_res.hit_x), 64'(want.hit_x));
                    if (o_res.hit_y !== want.hit_y)
                        report_mismatch("hit_y", 64'(o_res.hit_y), 64'(want.hit_y));
                    if (o_res.hit_z !== want.hit_z)
                        report_mismatch("hit_z", 64'(o_res.hit_z), 64'(want.hit_z));
                    if (o_res.degenerate !== want.degenerate)
                        report_mismatch("degenerate", 64'(o_res.degenerate),
                                        64'(want.degenerate));
                end
            end
        end
        i_res_stall <= ($urandom_range(99) < res_idle_pct);
    end

    task automatic reg_write(rsi_pkg::t_reg_idx idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rsi_pkg::REG_CENTER_X:       sph_cx = value;
            rsi_pkg::REG_CENTER_Y:       sph_cy = value;
            rsi_pkg::REG_CENTER_Z:       sph_cz = value;
            rsi_pkg::REG_RADIUS_SQUARED: sph_r2 = value;
            default: ;
        endcase
    endtask

    task automatic reg_check(rsi_pkg::t_reg_idx idx, logic [31:0] want);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch(idx.name(), 64'(prdata), 64'(want));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] r2);
        reg_write(rsi_pkg::REG_CENTER_X, x);
        reg_write(rsi_pkg::REG_CENTER_Y, y);
        reg_write(rsi_pkg::REG_CENTER_Z, z);
        reg_write(rsi_pkg::REG_RADIUS_SQUARED, r2);
    endtask

    task automatic send_request(rsi_pkg::t_req r);
        while ($urandom_range(99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_req_stall);
        pending_results.push_back(trace_ray(r));
    endtask

    task automatic drain;
        i_req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] edge_value();
        case ($urandom_range(6))
            0: return C_MIN;
            1: return C_MAX;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] spread(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic rsi_pkg::t_req noise_request();
        rsi_pkg::t_req r;
        r.origin_x = $urandom; r.origin_y = $urandom; r.origin_z = $urandom;
        r.dir_x = $urandom; r.dir_y = $urandom; r.dir_z = $urandom;
        r.min_time = $urandom; r.max_time = $urandom;
        if ($urandom_range(3) == 0) r.dir_x = edge_value();
        if ($urandom_range(3) == 0) r.origin_y = edge_value();
        if ($urandom_range(3) == 0) r.max_time = edge_value();
        return r;
    endfunction

    // ray aimed near the sphere center from a modest distance
    function automatic rsi_pkg::t_req aimed_request();
        rsi_pkg::t_req r;
        int sh;
        sh = $urandom_range(8, 1);
        r.origin_x = $signed(sph_cx) + $signed(spread(200 << FRAC));
        r.origin_y = $signed(sph_cy) + $signed(spread(200 << FRAC));
        r.origin_z = $signed(sph_cz) + $signed(spread(200 << FRAC));
        r.dir_x = (($signed(sph_cx) - $signed(r.origin_x)) >>> sh) + $signed(spread(1 << 13));
        r.dir_y = (($signed(sph_cy) - $signed(r.origin_y)) >>> sh) + $signed(spread(1 << 13));
        r.dir_z = (($signed(sph_cz) - $signed(r.origin_z)) >>> sh) + $signed(spread(1 << 13));
        r.min_time = ($urandom_range(3) == 0) ? spread(64 << FRAC) : 32'h0;
        r.max_time = ($urandom_range(3) == 0) ? $urandom_range(C_MAX) : C_MAX;
        return r;
    endfunction

    function automatic rsi_pkg::t_req make_ray(logic [31:0] ox, logic [31:0] oy,
                                               logic [31:0] oz, logic [31:0] dx,
                                               logic [31:0] dy, logic [31:0] dz,
                                               logic [31:0] tmin, logic [31:0] tmax);
        rsi_pkg::t_req r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.min_time = tmin; r.max_time = tmax;
        return r;
    endfunction

    task automatic test_reset_values;
        reg_check(rsi_pkg::REG_CENTER_X, 32'h0);
        reg_check(rsi_pkg::REG_CENTER_Y, 32'h0);
        reg_check(rsi_pkg::REG_CENTER_Z, 32'h0);
        reg_check(rsi_pkg::REG_RADIUS_SQUARED, 32'h0001_0000);
    endtask

    task automatic test_directed;
        localparam logic [31:0] ONE = 32'h0001_0000;
        // near root hit, far root from inside, zero and tiny direction
        send_request(make_ray(0, 0, -5 * ONE, 0, 0, ONE, 0, C_MAX));
        send_request(make_ray(0, 0, 0, 0, ONE, 0, 0, C_MAX));
        send_request(make_ray(ONE, ONE, ONE, 0, 0, 0, 0, C_MAX));
        send_request(make_ray(0, 0, -5 * ONE, 1, 0, 0, 0, C_MAX));
        // empty time range, plain miss, root behind origin
        send_request(make_ray(0, 0, -5 * ONE, 0, 0, ONE, 10 * ONE, ONE));
        send_request(make_ray(3 * ONE, 0, -5 * ONE, 0, 0, ONE, 0, C_MAX));
        send_request(make_ray(0, 0, 5 * ONE, 0, 0, ONE, 0, C_MAX));
        send_request(make_ray(0, 0, -5 * ONE, 0, 0, -ONE, C_MIN, C_MAX));
        // extremes everywhere
        send_request(make_ray(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_request(make_ray(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_request(make_ray(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
        send_request(make_ray(C_MAX, C_MIN, 0, C_MIN, C_MAX, 1, C_MIN, C_MAX));
        send_request(make_ray(0, 0, 0, C_MAX, 0, 0, C_MIN, C_MAX));
        send_request(make_ray('1, '1, '1, '1, '1, '1, '1, '1));
        send_request(make_ray(0, 0, -2 * ONE, 0, 0, ONE, ONE, ONE));
        drain();
    endtask

    task automatic test_sphere_settings;
        logic [31:0] setting[6][4];
        setting = '{
            '{C_MIN, C_MIN, C_MIN, 32'h0},
            '{C_MAX, C_MAX, C_MAX, 32'hffff_ffff},
            '{32'h0, 32'h0, 32'h0, 32'h0},
            '{C_MAX, C_MIN, 32'h0, 32'h0001_0000},
            '{32'h0010_0000, 32'hfff0_0000, 32'h0020_0000, 32'h0064_0000},
            '{$urandom, $urandom, $urandom, $urandom}
        };
        foreach (setting[i]) begin
            set_sphere(setting[i][0], setting[i][1], setting[i][2], setting[i][3]);
            repeat (50) send_request(($urandom_range(1) == 0) ? aimed_request()
                                                              : noise_request());
            drain();
        end
    endtask

    task automatic test_random_rays(int count);
        int r;
        r = $urandom_range(40, 1);
        set_sphere(spread(1000 << FRAC), spread(1000 << FRAC), spread(1000 << FRAC),
                   (r * r) << FRAC);
        for (int n = 0; n < count; n++) begin
            send_request(($urandom_range(99) < 75) ? aimed_request() : noise_request());
            // hold off once until the pipeline is empty
            if (n == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_req_valid <= 1'b0;
        i_req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        errors = 0;
        sph_cx = 0;
        sph_cy = 0;
        sph_cz = 0;
        sph_r2 = 32'h0001_0000;
        req_idle_pct = 37;
        res_idle_pct = 86;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_sphere_settings();
        test_random_rays(400);
        req_idle_pct = 86;
        res_idle_pct = 37;
        test_random_rays(400);
        req_idle_pct = 0;
        res_idle_pct = 0;
        test_random_rays(420);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_mul.sv
rtl/rsi_sqrt.sv
rtl/rsi_div.sv
rtl/rsi_queue.sv
rtl/rsi_front.sv
rtl/rsi_back.sv
rtl/ray_sphere_intersect.sv
tb/ray_sphere_intersect_tb.sv
